// ----- rtl/crsf_pkg.sv -----
// Shared constants and types for the serial frame deframer.
// No dependencies; imported by the interfaces and by every rtl module.
`default_nettype none

package crsf_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned POS_W     = 6;
   localparam int unsigned CNT_W     = 16;
   localparam int unsigned MAXLEN_W  = 7;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_A  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_B  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN  = 2'd3;

   localparam logic [BYTE_W-1:0]   START_A_RST  = 8'd238;
   localparam logic [BYTE_W-1:0]   START_B_RST  = 8'd200;
   localparam logic [BYTE_W-1:0]   CRC_POLY_RST = 8'd213;
   localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = 7'd64;

   // frame length arithmetic: length byte plus two, up to 257
   localparam int unsigned LEN_W = 9;
   localparam logic [LEN_W-1:0] LEN_ADJ = 9'd2;
   localparam logic [LEN_W-1:0] MIN_LEN = 9'd4;
   // bytes needed before the length byte can be judged
   localparam int unsigned HDR_FILL = 3;
   // first byte covered by the CRC (type byte)
   localparam int unsigned CRC_FIRST = 2;

   localparam int unsigned RES_CNT_W   = 7;
   localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 7'd64;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef struct packed {
      logic clear;
      logic step;
   } crc_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/crsf_req_if.sv -----
// Input channel: one received serial byte per word.
// Depends on crsf_pkg.
`default_nettype none

interface crsf_req_if;
   import crsf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/crsf_rsp_if.sv -----
// Result channel: frame bytes and CRC error notices with running counts.
// Depends on crsf_pkg.
`default_nettype none

interface crsf_rsp_if;
   import crsf_pkg::*;

   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [BYTE_W-1:0] frame_byte;
   logic [POS_W-1:0]  byte_position;
   logic              last_of_run;
   logic [CNT_W-1:0]  good_frames;
   logic [CNT_W-1:0]  bad_frames;

   modport source (output valid, output result_kind, output frame_byte,
                   output byte_position, output last_of_run,
                   output good_frames, output bad_frames, input ready);
   modport sink   (input valid, input result_kind, input frame_byte,
                   input byte_position, input last_of_run,
                   input good_frames, input bad_frames, output ready);
endinterface

`default_nettype wire

// ----- rtl/crsf_store.sv -----
// Circular frame buffer: one write and one registered read per cycle.
// Positions are relative to the head pointer. Depends on crsf_pkg.
`default_nettype none

module crsf_store #(
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = $clog2(DEPTH),
   localparam int unsigned CW = $clog2(DEPTH + 1)
) (
   input  wire logic                       clock,
   input  wire logic [AW-1:0]              head,
   input  wire logic                       wr_en,
   input  wire logic [CW-1:0]              wr_pos,
   input  wire logic [crsf_pkg::BYTE_W-1:0] wr_data,
   input  wire logic [CW-1:0]              rd_pos,
   output logic      [crsf_pkg::BYTE_W-1:0] rd_data
);
   import crsf_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;

   function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
      logic [CW:0] sum;
      begin
         sum = (CW+1)'(base) + (CW+1)'(ofs);
         if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
         end
         return sum[AW-1:0];
      end
   endfunction

   assign wr_addr = wrap_addr(head, wr_pos);
   assign rd_addr = wrap_addr(head, rd_pos);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/crsf_crc_unit.sv -----
// CRC-8 accumulator, MSB first, one byte folded in per step.
// Depends on crsf_pkg (crc_ctrl_type).
`default_nettype none

module crsf_crc_unit (
   input  wire logic                        clock,
   input  wire crsf_pkg::crc_ctrl_type      ctrl,
   input  wire logic [crsf_pkg::BYTE_W-1:0] poly,
   input  wire logic [crsf_pkg::BYTE_W-1:0] data,
   output logic      [crsf_pkg::BYTE_W-1:0] crc
);
   import crsf_pkg::*;

   logic [BYTE_W-1:0] crc_ff;
   logic [BYTE_W-1:0] crc_in;
   logic [BYTE_W-1:0] folded;

   always_comb begin
      folded = crc_ff ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         if (folded[BYTE_W-1]) begin
            folded = {folded[BYTE_W-2:0], 1'b0} ^ poly;
         end else begin
            folded = {folded[BYTE_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      priority if (ctrl.clear) begin
         crc_in = '0;
      end else if (ctrl.step) begin
         crc_in = folded;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

// ----- rtl/crsf_frame_deframer.sv -----
// Serial frame deframer: after each accepted byte the sequencer scans for a start byte,
// checks the length, runs the CRC one stored byte per cycle and streams a good frame or flags a bad one.
// Sequence: scan for a start byte, read the header, fold the CRC over the stored frame, then
// one output word per cycle while the sink is ready; the next byte is taken once processing
// is back in idle.
// Reset (synchronous): counters, fill level and registers restored; store contents kept.
`default_nettype none

module crsf_frame_deframer #(
   parameter int unsigned MAX_FRAME = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   crsf_req_if.sink                            req_chan,
   crsf_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [crsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [crsf_pkg::BYTE_W-1:0]    csr_wdata
);
   import crsf_pkg::*;

   localparam int unsigned AW = $clog2(MAX_FRAME);
   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ALIGN = 7'b0000010,
      S_HDR   = 7'b0000100,
      S_LEN   = 7'b0001000,
      S_CRC   = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_ERR   = 7'b1000000
   } state_type;

   // configuration
   logic [BYTE_W-1:0]   start_a_ff;
   logic [BYTE_W-1:0]   start_b_ff;
   logic [BYTE_W-1:0]   poly_ff;
   logic [MAXLEN_W-1:0] max_len_ff;

   // sequencer
   state_type      state_ff, state_in;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           dv_ff, dv_in;
   logic [CW-1:0]  total_ff, total_in;
   logic [RES_CNT_W-1:0] nres_ff, nres_in;
   logic [CNT_W-1:0] good_ff, good_in;
   logic [CNT_W-1:0] bad_ff, bad_in;

   // output word
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]  rsp_good_ff, rsp_good_in;
   logic [CNT_W-1:0]  rsp_bad_ff, rsp_bad_in;
   logic              rsp_load;

   // store and crc hookup
   logic              wr_en;
   logic [CW-1:0]     rd_pos;
   logic [BYTE_W-1:0] rd_data;
   crc_ctrl_type      crc_ctrl;
   logic [BYTE_W-1:0] crc_val;

   logic              req_fire;
   logic              slot_free;
   logic              out_full;
   logic              match;
   logic [LEN_W-1:0]  maxlen;
   logic [LEN_W-1:0]  total_calc;
   logic [CW-1:0]     skip;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
      logic [CW:0] sum;
      begin
         sum = (CW+1)'(base) + (CW+1)'(ofs);
         if (sum >= (CW+1)'(MAX_FRAME)) begin
            sum = sum - (CW+1)'(MAX_FRAME);
         end
         return sum[AW-1:0];
      end
   endfunction

   crsf_store #(
      .DEPTH (MAX_FRAME)
   ) u_store (
      .clock   (clock),
      .head    (head_ff),
      .wr_en   (wr_en),
      .wr_pos  (fill_ff),
      .wr_data (req_chan.rx_byte),
      .rd_pos  (rd_pos),
      .rd_data (rd_data)
   );

   crsf_crc_unit u_crc (
      .clock (clock),
      .ctrl  (crc_ctrl),
      .poly  (poly_ff),
      .data  (rd_data),
      .crc   (crc_val)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   // past the result limit a run is consumed without output
   assign out_full       = (nres_ff >= MAX_RESULTS);
   assign match          = dv_ff && (rd_data == start_a_ff || rd_data == start_b_ff);
   assign maxlen         = ((LEN_W)'(max_len_ff) < (LEN_W)'(MAX_FRAME)) ?
                           (LEN_W)'(max_len_ff) : (LEN_W)'(MAX_FRAME);
   assign total_calc     = (LEN_W)'(rd_data) + LEN_ADJ;
   assign skip           = idx_ff - CW'(1);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      dv_in     = dv_ff;
      total_in  = total_ff;
      nres_in   = nres_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      wr_en     = 1'b0;
      rd_pos    = idx_ff;
      crc_ctrl  = '0;
      rsp_load  = 1'b0;
      rsp_kind_in = KIND_DATA;
      rsp_byte_in = rd_data;
      rsp_pos_in  = POS_W'(idx_ff);
      rsp_last_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (fill_ff != CW'(MAX_FRAME)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end
               nres_in  = '0;
               idx_in   = '0;
               dv_in    = 1'b0;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            // rd_data holds position idx-1 when dv is set
            priority if (match) begin
               head_in  = advance(head_ff, skip);
               fill_in  = fill_ff - skip;
               dv_in    = 1'b0;
               state_in = S_HDR;
            end else if (idx_ff >= fill_ff) begin
               fill_in  = '0;
               dv_in    = 1'b0;
               state_in = S_HDR;
            end else begin
               dv_in  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
         end
         S_HDR: begin
            if (fill_ff < CW'(HDR_FILL)) begin
               state_in = S_IDLE;
            end else begin
               rd_pos   = CW'(1);
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            priority if (total_calc < MIN_LEN || total_calc > maxlen) begin
               // bad length: drop the start byte and rescan
               idx_in   = CW'(1);
               dv_in    = 1'b0;
               state_in = S_ALIGN;
            end else if ((LEN_W)'(fill_ff) < total_calc) begin
               state_in = S_IDLE;
            end else begin
               total_in       = CW'(total_calc);
               idx_in         = CW'(CRC_FIRST);
               dv_in          = 1'b0;
               crc_ctrl.clear = 1'b1;
               state_in       = S_CRC;
            end
         end
         S_CRC: begin
            if (dv_ff && idx_ff == total_ff) begin
               // rd_data is the trailing check byte
               dv_in = 1'b0;
               if (crc_val == rd_data) begin
                  if (good_ff != '1) begin
                     good_in = good_ff + CNT_W'(1);
                  end
                  idx_in   = '0;
                  rd_pos   = '0;
                  state_in = S_EMIT;
               end else begin
                  if (bad_ff != '1) begin
                     bad_in = bad_ff + CNT_W'(1);
                  end
                  state_in = S_ERR;
               end
            end else begin
               crc_ctrl.step = dv_ff;
               dv_in         = 1'b1;
               idx_in        = idx_ff + CW'(1);
            end
         end
         S_EMIT: begin
            // rd_data always holds position idx here
            if (out_full || slot_free) begin
               if (!out_full) begin
                  rsp_load    = 1'b1;
                  rsp_last_in = (idx_ff == total_ff - CW'(1));
                  nres_in     = nres_ff + RES_CNT_W'(1);
               end
               rd_pos = idx_ff + CW'(1);
               idx_in = idx_ff + CW'(1);
               if (idx_ff == total_ff - CW'(1)) begin
                  head_in  = advance(head_ff, total_ff);
                  fill_in  = fill_ff - total_ff;
                  idx_in   = '0;
                  dv_in    = 1'b0;
                  state_in = S_ALIGN;
               end
            end
         end
         S_ERR: begin
            if (out_full || slot_free) begin
               if (!out_full) begin
                  rsp_load    = 1'b1;
                  rsp_kind_in = KIND_ERROR;
                  rsp_byte_in = '0;
                  rsp_pos_in  = '0;
                  rsp_last_in = 1'b1;
                  nres_in     = nres_ff + RES_CNT_W'(1);
               end
               head_in  = advance(head_ff, total_ff);
               fill_in  = fill_ff - total_ff;
               idx_in   = '0;
               dv_in    = 1'b0;
               state_in = S_ALIGN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      rsp_good_in = good_ff;
      rsp_bad_in  = bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         dv_ff        <= 1'b0;
         nres_ff      <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         dv_ff        <= dv_in;
         nres_ff      <= nres_in;
         good_ff      <= good_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_pos_ff  <= rsp_pos_in;
         rsp_last_ff <= rsp_last_in;
         rsp_good_ff <= rsp_good_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_a_ff <= START_A_RST;
         start_b_ff <= START_B_RST;
         poly_ff    <= CRC_POLY_RST;
         max_len_ff <= MAX_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_A:  start_a_ff <= csr_wdata;
            CSR_START_B:  start_b_ff <= csr_wdata;
            CSR_CRC_POLY: poly_ff    <= csr_wdata;
            CSR_MAX_LEN:  max_len_ff <= csr_wdata[MAXLEN_W-1:0];
            default:      start_a_ff <= start_a_ff;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_kind   = rsp_kind_ff;
   assign rsp_chan.frame_byte    = rsp_byte_ff;
   assign rsp_chan.byte_position = rsp_pos_ff;
   assign rsp_chan.last_of_run   = rsp_last_ff;
   assign rsp_chan.good_frames   = rsp_good_ff;
   assign rsp_chan.bad_frames    = rsp_bad_ff;

`ifndef SYNTHESIS
   // a frame under check or being sent is fully held in the store
   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CRC || state_ff == S_EMIT || state_ff == S_ERR) |->
         (total_ff <= fill_ff && (LEN_W)'(total_ff) >= MIN_LEN))
      else $error("frame length exceeds stored bytes");

   // an accepted word lands in the store unless it is full
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && fill_ff != CW'(MAX_FRAME)) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("fill level did not advance on accept");

   // frame counts only move on a CRC decision
   a_count_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (!$stable(good_ff) || !$stable(bad_ff))) |->
         $past(state_ff == S_CRC))
      else $error("frame counter changed outside CRC decision");
`endif

endmodule

`default_nettype wire
